FILE: rtl/spo_pkg.sv
// ----------------------------------------------------------------------------
// spo_pkg
// Shared widths, calibration constants, status codes and the structs that
// join the window tracker, the controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
package spo_pkg;

   localparam int SAMPLE_W   = 18;
   localparam int WLEN_W     = 13;
   localparam int WLEN_RESET = 1000;

   localparam int NUM_W      = 2 * SAMPLE_W;
   localparam int DVD_W      = NUM_W + 14;
   localparam int DSH_W      = NUM_W + 16;
   localparam int QUO_W      = 16;
   localparam int DIV_STEP_W = $clog2(QUO_W);
   localparam int SQ_W       = 2 * QUO_W;

   localparam int KQ_W       = 21;
   localparam int K1_W       = 22;
   localparam int C0_W       = 24;
   localparam int LIN_W      = K1_W + QUO_W;
   localparam int QUAD_W     = KQ_W + SQ_W;
   localparam int V_W        = 56;
   localparam int RES_W      = 16;
   localparam int STAT_W     = 2;

   // Q16 calibration terms, linear and offset parts of both curves merged
   localparam logic [KQ_W-1:0] CAL_QUAD = KQ_W'(1082596);
   localparam logic [K1_W-1:0] CAL_LIN  = K1_W'(519543 + 25 * 65536);
   localparam logic [C0_W-1:0] CAL_OFS  = C0_W'(8158911 + 125 * 65536);

   localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FAULT = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAT   = 2'd2;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red_max;
      logic [SAMPLE_W-1:0] red_min;
      logic [SAMPLE_W-1:0] ir_max;
      logic [SAMPLE_W-1:0] ir_min;
   } spo_ext_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic prep;
      logic div_step;
      logic sq;
      logic quad;
      logic sum;
   } spo_cmd_type;

   typedef struct packed {
      logic win_end;
   } spo_stat_type;

endpackage

FILE: rtl/spo_track.sv
// ----------------------------------------------------------------------------
// spo_track
// Window length register, sample counter and running extremes of both
// channels. Flags the word that closes a window and hands out its extremes.
// ----------------------------------------------------------------------------
module spo_track #(
   parameter int MAX_WINDOW = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [spo_pkg::WLEN_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [spo_pkg::SAMPLE_W-1:0]      req_red_sample,
   input  logic [spo_pkg::SAMPLE_W-1:0]      req_ir_sample,
   input  logic                              busy,
   output spo_pkg::spo_stat_type             stat,
   output spo_pkg::spo_ext_type              ext
);

   localparam int CNT_W = $clog2(MAX_WINDOW);
   localparam int CMP_W = (CNT_W + 1 > spo_pkg::WLEN_W) ? CNT_W + 1 : spo_pkg::WLEN_W;

   logic [CNT_W-1:0]           count_ff;
   logic [spo_pkg::WLEN_W-1:0] wlen_ff;
   spo_pkg::spo_ext_type       ext_ff;
   spo_pkg::spo_ext_type       ext_in;
   logic [CMP_W-1:0]           win_eff;
   logic [CMP_W-1:0]           cnt_next;
   logic                       first;
   logic                       ends;
   logic                       accept;

   always_comb begin
      priority if (wlen_ff == '0) begin
         win_eff = CMP_W'(1);
      end else if (CMP_W'(wlen_ff) > CMP_W'(MAX_WINDOW)) begin
         win_eff = CMP_W'(MAX_WINDOW);
      end else begin
         win_eff = CMP_W'(wlen_ff);
      end
   end

   assign cnt_next  = CMP_W'(count_ff) + CMP_W'(1);
   assign ends      = cnt_next >= win_eff;
   assign first     = count_ff == '0;
   assign req_ready = !(ends && busy);
   assign accept    = req_valid && req_ready;

   always_comb begin
      ext_in.red_max = (first || req_red_sample > ext_ff.red_max) ? req_red_sample
                                                                   : ext_ff.red_max;
      ext_in.red_min = (first || req_red_sample < ext_ff.red_min) ? req_red_sample
                                                                   : ext_ff.red_min;
      ext_in.ir_max  = (first || req_ir_sample > ext_ff.ir_max) ? req_ir_sample
                                                                 : ext_ff.ir_max;
      ext_in.ir_min  = (first || req_ir_sample < ext_ff.ir_min) ? req_ir_sample
                                                                 : ext_ff.ir_min;
   end

   assign ext          = ext_in;
   assign stat.win_end = accept && ends;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wlen_ff  <= spo_pkg::WLEN_W'(spo_pkg::WLEN_RESET);
      end else begin
         if (csr_wr_en) begin
            wlen_ff <= csr_wr_data;
         end
         if (accept) begin
            count_ff <= ends ? '0 : cnt_next[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ext_ff <= ext_in;
      end
   end

endmodule

FILE: rtl/spo_ctrl.sv
// ----------------------------------------------------------------------------
// spo_ctrl
// Sequencer for the end-of-window computation: products, 16-step divide,
// calibration polynomial and the held result word.
// ----------------------------------------------------------------------------
module spo_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  spo_pkg::spo_stat_type stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  busy,
   output spo_pkg::spo_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_DIV,
      ST_SQ,
      ST_QUAD,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type                        state_ff;
   logic [spo_pkg::DIV_STEP_W-1:0]   step_ff;
   logic                             rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && stat.win_end;
      cmd.mul      = state_ff == ST_MUL;
      cmd.prep     = state_ff == ST_PREP;
      cmd.div_step = state_ff == ST_DIV;
      cmd.sq       = state_ff == ST_SQ;
      cmd.quad     = state_ff == ST_QUAD;
      cmd.sum      = state_ff == ST_SUM;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (stat.win_end) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               step_ff  <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == '1) begin
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               state_ff <= ST_QUAD;
            end
            ST_QUAD: begin
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: rtl/spo_dp.sv
// ----------------------------------------------------------------------------
// spo_dp
// Arithmetic datapath: extreme snapshot, cross products, restoring divide
// for R in Q4.12, calibration polynomial in Q40 and saturated result word.
// ----------------------------------------------------------------------------
module spo_dp (
   input  logic                              clock,
   input  spo_pkg::spo_cmd_type              cmd,
   input  spo_pkg::spo_ext_type              ext,
   output logic [spo_pkg::RES_W-1:0]         ratio_q12,
   output logic signed [spo_pkg::RES_W-1:0]  spo2_q8,
   output logic [spo_pkg::STAT_W-1:0]        status
);

   localparam int V_W  = spo_pkg::V_W;
   localparam int SH_W = V_W - 33;
   localparam logic signed [V_W-1:0]  OFS_TERM =
      $signed((V_W'(spo_pkg::CAL_OFS) << 24) + (V_W'(1) << 32));
   localparam logic signed [SH_W-1:0] S_MAX = SH_W'(32767);
   localparam logic signed [SH_W-1:0] S_MIN = -SH_W'(32768);

   spo_pkg::spo_ext_type               snap_ff;
   logic [spo_pkg::NUM_W-1:0]          num_ff;
   logic [spo_pkg::NUM_W-1:0]          den_ff;
   logic                               fault_ff;
   logic [spo_pkg::DVD_W-1:0]          rem_ff;
   logic [spo_pkg::DSH_W-1:0]          dsh_ff;
   logic [spo_pkg::QUO_W-1:0]          quo_ff;
   logic                               ovf_ff;
   logic [spo_pkg::QUO_W-1:0]          rq_ff;
   logic [spo_pkg::SQ_W-1:0]           sq_ff;
   logic [spo_pkg::LIN_W-1:0]          lin_ff;
   logic [spo_pkg::QUAD_W-1:0]         quad_ff;
   logic signed [V_W-1:0]              part_ff;
   logic [spo_pkg::RES_W-1:0]          ratio_ff;
   logic signed [spo_pkg::RES_W-1:0]   spo2_ff;
   logic [spo_pkg::STAT_W-1:0]         status_ff;

   logic [spo_pkg::DVD_W-1:0]          dvd;
   logic [spo_pkg::DVD_W+2:0]          dvd_x;
   logic [spo_pkg::DSH_W-1:0]          rem_x;
   logic [spo_pkg::DSH_W-1:0]          rem_diff;
   logic                               rem_ge;
   logic [spo_pkg::QUO_W-1:0]          rq;
   logic signed [V_W-1:0]              v_sum;
   logic signed [SH_W-1:0]             s_val;

   assign dvd      = spo_pkg::DVD_W'({num_ff, 13'b0}) + spo_pkg::DVD_W'(den_ff);
   assign dvd_x    = (spo_pkg::DVD_W + 3)'(dvd);
   assign rem_x    = spo_pkg::DSH_W'(rem_ff);
   assign rem_ge   = rem_x >= dsh_ff;
   assign rem_diff = rem_x - dsh_ff;
   assign rq       = ovf_ff ? '1 : quo_ff;
   assign v_sum    = part_ff - $signed(V_W'(quad_ff));
   assign s_val    = v_sum[V_W-1:33];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         snap_ff <= ext;
      end
      if (cmd.mul) begin
         num_ff   <= spo_pkg::NUM_W'(snap_ff.red_max) * spo_pkg::NUM_W'(snap_ff.ir_min);
         den_ff   <= spo_pkg::NUM_W'(snap_ff.red_min) * spo_pkg::NUM_W'(snap_ff.ir_max);
         fault_ff <= (snap_ff.red_min == '0) || (snap_ff.ir_min == '0);
      end
      if (cmd.prep) begin
         rem_ff <= dvd;
         dsh_ff <= {den_ff, 16'b0};
         ovf_ff <= dvd_x >= {den_ff, 17'b0};
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? rem_diff[spo_pkg::DVD_W-1:0] : rem_ff;
         quo_ff <= {quo_ff[spo_pkg::QUO_W-2:0], rem_ge};
         dsh_ff <= dsh_ff >> 1;
      end
      if (cmd.sq) begin
         rq_ff  <= rq;
         sq_ff  <= spo_pkg::SQ_W'(rq) * spo_pkg::SQ_W'(rq);
         lin_ff <= spo_pkg::LIN_W'(spo_pkg::CAL_LIN) * spo_pkg::LIN_W'(rq);
      end
      if (cmd.quad) begin
         quad_ff <= spo_pkg::QUAD_W'(spo_pkg::CAL_QUAD) * spo_pkg::QUAD_W'(sq_ff);
         part_ff <= OFS_TERM - $signed(V_W'(lin_ff) << 12);
      end
      if (cmd.sum) begin
         if (fault_ff) begin
            ratio_ff  <= '0;
            spo2_ff   <= '0;
            status_ff <= spo_pkg::STATUS_FAULT;
         end else begin
            ratio_ff <= rq_ff;
            priority if (s_val > S_MAX) begin
               spo2_ff <= 16'sh7FFF;
            end else if (s_val < S_MIN) begin
               spo2_ff <= 16'sh8000;
            end else begin
               spo2_ff <= s_val[spo_pkg::RES_W-1:0];
            end
            status_ff <= (ovf_ff || s_val > S_MAX || s_val < S_MIN) ? spo_pkg::STATUS_SAT
                                                                     : spo_pkg::STATUS_OK;
         end
      end
   end

   assign ratio_q12 = ratio_ff;
   assign spo2_q8   = spo2_ff;
   assign status    = status_ff;

endmodule

FILE: rtl/spo2_ratio_window_estimator.sv
// ----------------------------------------------------------------------------
// spo2_ratio_window_estimator
// Windowed red/infrared extreme tracking with ratio-of-ratios and SpO2
// calibration at each window end.
// ----------------------------------------------------------------------------
// Sample words are taken one per clock but for the wait below. The word that
// closes a window latches its four extremes into the datapath; the result
// word (R in Q4.12, SpO2 in Q8.8, status) is then formed by products and
// setup, the one-bit-per-cycle restoring divider, then polynomial and
// saturation, the last of which loads the output register. The next window
// fills meanwhile;
// only a word that would close a window waits while the previous result is
// still being computed or not yet taken, so with windows of 23 or more words
// the input never stalls on a prompt consumer. csr_wr_data sets the window
// length (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW).
// ----------------------------------------------------------------------------
module spo2_ratio_window_estimator #(
   parameter int MAX_WINDOW = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [spo_pkg::WLEN_W-1:0]        csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [spo_pkg::SAMPLE_W-1:0]      req_red_sample,
   input  logic [spo_pkg::SAMPLE_W-1:0]      req_ir_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spo_pkg::RES_W-1:0]         rsp_ratio_q12,
   output logic signed [spo_pkg::RES_W-1:0]  rsp_spo2_q8,
   output logic [spo_pkg::STAT_W-1:0]        rsp_status
);

   spo_pkg::spo_stat_type stat;
   spo_pkg::spo_ext_type  ext;
   spo_pkg::spo_cmd_type  cmd;
   logic                  busy;

   spo_track #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_track (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_red_sample (req_red_sample),
      .req_ir_sample  (req_ir_sample),
      .busy           (busy),
      .stat           (stat),
      .ext            (ext)
   );

   spo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .busy      (busy),
      .cmd       (cmd)
   );

   spo_dp u_dp (
      .clock     (clock),
      .cmd       (cmd),
      .ext       (ext),
      .ratio_q12 (rsp_ratio_q12),
      .spo2_q8   (rsp_spo2_q8),
      .status    (rsp_status)
   );

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> busy)
      else $error("input stalled while sequencer idle");

   a_window_end_free: assert property (@(posedge clock) disable iff (reset)
      stat.win_end |-> !busy && !rsp_valid)
      else $error("window closed while previous result pending");

   a_fault_zeroes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == spo_pkg::STATUS_FAULT |->
         rsp_ratio_q12 == '0 && rsp_spo2_q8 == '0)
      else $error("fault word carries nonzero result");

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy && !rsp_valid)
      else $error("sequencer did not start on window end");

endmodule
